// File: sv/single_wire_humidity_sensor_reader_top_macros.svh
// assertion macros for the sensor reader checker
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_MACROS_SVH

// plain clocked property, disabled in reset
`define SWHSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define SWHSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/swhsr_pkg.sv
`timescale 1ns / 1ps

package swhsr_pkg;

    localparam int unsigned WAKE_W     = 16;
    localparam int unsigned EDGE_W     = 8;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned BIT_CNT_W  = 6;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NUM_BYTES  = 5;
    localparam int unsigned DATA_BITS  = BYTE_W * NUM_BYTES;
    localparam int unsigned SUM_W      = BYTE_W + 2;

    localparam logic [WAKE_W-1:0]    RELEASE_TICKS   = 16'd40;
    localparam logic [LEVEL_W-1:0]   TIMEOUT_TICKS   = 8'd255;
    localparam logic [LEVEL_W-1:0]   ONE_THRESHOLD   = 8'd16;
    localparam logic [EDGE_W-1:0]    FIRST_DATA_EDGE = 8'd4;
    localparam logic [BIT_CNT_W-1:0] MAX_BITS        = 6'd40;

    localparam logic [WAKE_W-1:0] WAKE_TICKS_RESET = 16'd18000;
    localparam logic [EDGE_W-1:0] MAX_EDGES_RESET  = 8'd85;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EDGES  = 1'b1;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic {
        OP_TICK,
        OP_START
    } op_t;

    typedef struct packed {
        op_t  op;
        logic pin_level;
    } item_t;

endpackage

// File: sv/swhsr_if.sv
`timescale 1ns / 1ps

interface swhsr_item_if;
    logic valid;
    logic ready;
    logic command;
    logic pin_level;

    modport source (output valid, output command, output pin_level, input ready);
    modport sink (input valid, input command, input pin_level, output ready);
endinterface

interface swhsr_result_if;
    import swhsr_pkg::*;

    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic              checksum_ok;
    logic [BYTE_W-1:0] humidity_whole;
    logic [BYTE_W-1:0] humidity_tenths;
    logic [BYTE_W-1:0] temperature_whole;
    logic [BYTE_W-1:0] temperature_tenths;
    logic [BYTE_W-1:0] check_byte;

    modport source (
        output valid, output drive_low, output busy_res, output done_res,
        output timed_out, output checksum_ok, output humidity_whole,
        output humidity_tenths, output temperature_whole,
        output temperature_tenths, output check_byte, input ready
    );
    modport sink (
        input valid, input drive_low, input busy_res, input done_res,
        input timed_out, input checksum_ok, input humidity_whole,
        input humidity_tenths, input temperature_whole,
        input temperature_tenths, input check_byte, output ready
    );
endinterface

// File: sv/swhsr_front.sv
`timescale 1ns / 1ps

module swhsr_front (
    input  logic              clk,
    input  logic              rst_n,
    swhsr_item_if.sink        item,
    output logic              push_valid,
    input  logic              push_ready,
    output swhsr_pkg::item_t  push_item
);
    import swhsr_pkg::*;

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign item.ready = !item_valid_reg || push_ready;
    assign take       = item.valid && item.ready;

    // classify the request: start command or plain sample tick
    always_comb
    begin
        item_next.op        = item.command ? OP_START : OP_TICK;
        item_next.pin_level = item.pin_level;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign push_valid = item_valid_reg;
    assign push_item  = item_reg;

endmodule

// File: sv/swhsr_queue.sv
`timescale 1ns / 1ps

module swhsr_queue #(
    parameter int unsigned DEPTH = swhsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  swhsr_pkg::item_t  push_item,
    output logic              pop_valid,
    output swhsr_pkg::item_t  pop_item,
    input  logic              pop
);
    import swhsr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop_fire;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop_fire   = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/swhsr_core.sv
`timescale 1ns / 1ps

module swhsr_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 q_valid,
    input  swhsr_pkg::item_t                     q_item,
    output logic                                 q_pop,
    swhsr_result_if.source                       result
);
    import swhsr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAKE,
        PH_RELEASE,
        PH_SAMPLE
    } phase_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic              checksum_ok;
        logic [BYTE_W-1:0] humidity_whole;
        logic [BYTE_W-1:0] humidity_tenths;
        logic [BYTE_W-1:0] temperature_whole;
        logic [BYTE_W-1:0] temperature_tenths;
        logic [BYTE_W-1:0] check_byte;
    } result_t;

    logic [WAKE_W-1:0]    wake_ticks_reg;
    logic [EDGE_W-1:0]    max_edges_reg;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [WAKE_W-1:0]    phase_timer_reg;
    logic [WAKE_W-1:0]    phase_timer_next;
    logic [LEVEL_W-1:0]   level_count_reg;
    logic [LEVEL_W-1:0]   level_count_next;
    logic [EDGE_W-1:0]    edge_index_reg;
    logic [EDGE_W-1:0]    edge_index_next;
    logic                 last_level_reg;
    logic                 last_level_next;
    logic [BIT_CNT_W-1:0] bit_count_reg;
    logic [BIT_CNT_W-1:0] bit_count_next;
    logic [DATA_BITS-1:0] received_bits_reg;
    logic [DATA_BITS-1:0] received_bits_next;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    result_t              res_reg;
    result_t              res_next;

    logic [WAKE_W-1:0]    timer_inc;
    logic [LEVEL_W-1:0]   level_inc;
    logic [EDGE_W-1:0]    edge_inc;
    logic [2:0]           byte_sel;
    logic                 new_bit;
    logic                 done;
    logic                 tmo;
    logic [BYTE_W-1:0]    bytes [NUM_BYTES];
    logic [SUM_W-1:0]     sum;

    assign q_pop = q_valid && (!res_valid_reg || result.ready);

    assign timer_inc = phase_timer_reg + 1'b1;
    assign level_inc = level_count_reg + 1'b1;
    assign edge_inc  = edge_index_reg + 1'b1;
    assign byte_sel  = bit_count_reg[BIT_CNT_W-1:3];
    assign new_bit   = level_count_reg > ONE_THRESHOLD;

    always_comb
    begin
        phase_next         = phase_reg;
        phase_timer_next   = phase_timer_reg;
        level_count_next   = level_count_reg;
        edge_index_next    = edge_index_reg;
        last_level_next    = last_level_reg;
        bit_count_next     = bit_count_reg;
        received_bits_next = received_bits_reg;
        done               = 1'b0;
        tmo                = 1'b0;

        if (q_item.op == OP_START)
        begin
            // a start drops any read in progress
            level_count_next   = '0;
            edge_index_next    = '0;
            last_level_next    = 1'b1;
            bit_count_next     = '0;
            received_bits_next = '0;
            if (wake_ticks_reg <= WAKE_W'(1))
            begin
                phase_next       = PH_RELEASE;
                phase_timer_next = '0;
            end
            else
            begin
                phase_next       = PH_WAKE;
                phase_timer_next = WAKE_W'(1);
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_WAKE:
                begin
                    phase_timer_next = timer_inc;
                    if (timer_inc >= wake_ticks_reg)
                    begin
                        phase_next       = PH_RELEASE;
                        phase_timer_next = '0;
                    end
                end
                PH_RELEASE:
                begin
                    phase_timer_next = timer_inc;
                    if (timer_inc >= RELEASE_TICKS)
                    begin
                        phase_next       = PH_SAMPLE;
                        phase_timer_next = '0;
                        done             = edge_index_reg >= max_edges_reg;
                    end
                end
                PH_SAMPLE:
                begin
                    if (q_item.pin_level == last_level_reg)
                    begin
                        level_count_next = level_inc;
                        if (level_inc >= TIMEOUT_TICKS)
                        begin
                            done = 1'b1;
                            tmo  = 1'b1;
                        end
                    end
                    else
                    begin
                        last_level_next = q_item.pin_level;
                        // data bits sit on the even edge indices from four on, up to forty bits
                        if (edge_index_reg >= FIRST_DATA_EDGE && !edge_index_reg[0] &&
                            bit_count_reg < MAX_BITS)
                        begin
                            for (int k = 0; k < NUM_BYTES; k++)
                            begin
                                if (byte_sel == 3'(k))
                                begin
                                    received_bits_next[DATA_BITS-1-BYTE_W*k -: BYTE_W] =
                                        {received_bits_reg[DATA_BITS-2-BYTE_W*k -: BYTE_W-1],
                                         new_bit};
                                end
                            end
                            bit_count_next = bit_count_reg + 1'b1;
                        end
                        edge_index_next  = edge_inc;
                        level_count_next = '0;
                        done             = edge_inc >= max_edges_reg;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (done)
        begin
            phase_next = PH_IDLE;
        end
    end

    // bytes and check come from the bits after this request
    always_comb
    begin
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            bytes[k] = received_bits_next[DATA_BITS-1-BYTE_W*k -: BYTE_W];
        end
        sum = SUM_W'(bytes[0]) + SUM_W'(bytes[1]) + SUM_W'(bytes[2]) + SUM_W'(bytes[3]);

        res_next                    = '0;
        res_next.drive_low          = phase_next == PH_WAKE;
        res_next.busy_res           = phase_next != PH_IDLE;
        if (done)
        begin
            res_next.done_res           = 1'b1;
            res_next.timed_out          = tmo;
            res_next.checksum_ok        = (sum == SUM_W'(bytes[4])) && (sum != '0);
            res_next.humidity_whole     = bytes[0];
            res_next.humidity_tenths    = bytes[1];
            res_next.temperature_whole  = bytes[2];
            res_next.temperature_tenths = bytes[3];
            res_next.check_byte         = bytes[4];
        end

        if (q_pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_ticks_reg <= WAKE_TICKS_RESET;
            max_edges_reg  <= MAX_EDGES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAKE_TICKS: wake_ticks_reg <= cfg_data[WAKE_W-1:0];
                CFG_MAX_EDGES:  max_edges_reg  <= cfg_data[EDGE_W-1:0];
                default:        wake_ticks_reg <= wake_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_timer_reg   <= '0;
            level_count_reg   <= '0;
            edge_index_reg    <= '0;
            last_level_reg    <= 1'b1;
            bit_count_reg     <= '0;
            received_bits_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (q_pop)
            begin
                phase_reg         <= phase_next;
                phase_timer_reg   <= phase_timer_next;
                level_count_reg   <= level_count_next;
                edge_index_reg    <= edge_index_next;
                last_level_reg    <= last_level_next;
                bit_count_reg     <= bit_count_next;
                received_bits_reg <= received_bits_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.drive_low          = res_reg.drive_low;
    assign result.busy_res           = res_reg.busy_res;
    assign result.done_res           = res_reg.done_res;
    assign result.timed_out          = res_reg.timed_out;
    assign result.checksum_ok        = res_reg.checksum_ok;
    assign result.humidity_whole     = res_reg.humidity_whole;
    assign result.humidity_tenths    = res_reg.humidity_tenths;
    assign result.temperature_whole  = res_reg.temperature_whole;
    assign result.temperature_tenths = res_reg.temperature_tenths;
    assign result.check_byte         = res_reg.check_byte;

endmodule

// File: sv/single_wire_humidity_sensor_reader_top.sv
`timescale 1ns / 1ps
// path: each request is registered in the front input register and the queue, its result in the core
// throughput: one request per cycle while the result output is not stalled, set by the state update in the core
// the input register and the queue let the front keep taking requests while a result waits
// reset: rst_n low clears all control state at once, read goes idle, wake_ticks 18000,
// max_edges 85; no clearing pass

module single_wire_humidity_sensor_reader_top #(
    parameter int unsigned QUEUE_DEPTH = swhsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0] cfg_data,
    swhsr_item_if.sink                       item,
    swhsr_result_if.source                   result
);
    import swhsr_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    swhsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    swhsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    swhsr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .result    (result)
    );

endmodule

// File: sv/swhsr_checker.sv
`timescale 1ns / 1ps
`include "single_wire_humidity_sensor_reader_top_macros.svh"

module swhsr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       drive_low,
    input logic       busy_res,
    input logic       done_res,
    input logic       timed_out,
    input logic       checksum_ok,
    input logic [7:0] humidity_whole,
    input logic [7:0] check_byte
);

    // a stalled result holds
    `SWHSR_ASSERT(a_result_hold, out_valid && !out_ready |=> out_valid && $stable(done_res) && $stable(check_byte) && $stable(busy_res), "result changed while stalled")

    // a finished read leaves the block idle
    `SWHSR_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res && !drive_low, "done while still busy")

    // wake phase only inside a read
    `SWHSR_ASSERT_IMP(a_wake_busy, out_valid && drive_low, busy_res, "line driven low while idle")

    // status and data only on the finishing result
    `SWHSR_ASSERT_IMP(a_quiet_not_done, out_valid && !done_res, !timed_out && !checksum_ok && humidity_whole == 8'd0 && check_byte == 8'd0, "fields set outside done")

    // a good check needs a nonzero sum
    `SWHSR_ASSERT_IMP(a_check_nonzero, out_valid && checksum_ok, check_byte != 8'd0, "check passed on zero")

endmodule

bind single_wire_humidity_sensor_reader_top swhsr_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .drive_low      (result.drive_low),
    .busy_res       (result.busy_res),
    .done_res       (result.done_res),
    .timed_out      (result.timed_out),
    .checksum_ok    (result.checksum_ok),
    .humidity_whole (result.humidity_whole),
    .check_byte     (result.check_byte)
);

// File: verif/single_wire_humidity_sensor_reader_top_tb.sv
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_top_tb;
    import swhsr_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned RANDOM_READS = 2;
    localparam int unsigned PRINT_CAP = 40;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_WAKE,
        RD_RELEASE,
        RD_SAMPLE
    } read_phase_t;

    typedef enum int unsigned {
        FAULT_NONE,
        FAULT_STALL,
        FAULT_RESTART,
        FAULT_NOISE
    } read_fault_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy;
        logic              done;
        logic              timed_out;
        logic              checksum_ok;
        logic [BYTE_W-1:0] hum_whole;
        logic [BYTE_W-1:0] hum_tenths;
        logic [BYTE_W-1:0] temp_whole;
        logic [BYTE_W-1:0] temp_tenths;
        logic [BYTE_W-1:0] check;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    swhsr_item_if   item_ch ();
    swhsr_result_if result_ch ();

    single_wire_humidity_sensor_reader_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mirror of the reader state
    logic [WAKE_W-1:0]    wake_ticks_cfg;
    logic [EDGE_W-1:0]    max_edges_cfg;
    read_phase_t          rd_phase;
    logic [WAKE_W-1:0]    phase_timer;
    logic [LEVEL_W-1:0]   level_count;
    logic [EDGE_W-1:0]    edge_index;
    logic                 last_level;
    logic [BIT_CNT_W-1:0] bit_count;
    logic [DATA_BITS-1:0] rx_bits;

    reading_t    pending_readings[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned reads_finished = 0;
    int unsigned burst_left = 0;

    function automatic reading_t predict_reading(input op_t op, input logic pin);
        reading_t          r;
        logic              done;
        logic              tmo;
        int unsigned       byte_pos;
        logic [BYTE_W-1:0] cur;
        logic [SUM_W-1:0]  sum;
        done = 1'b0;
        tmo = 1'b0;
        if (op == OP_START)
        begin
            phase_timer = '0;
            level_count = '0;
            edge_index = '0;
            last_level = 1'b1;
            bit_count = '0;
            rx_bits = '0;
            if (wake_ticks_cfg <= 1)
                rd_phase = RD_RELEASE;
            else
            begin
                rd_phase = RD_WAKE;
                phase_timer = WAKE_W'(1);
            end
        end
        else
        begin
            case (rd_phase)
                RD_WAKE:
                begin
                    phase_timer = phase_timer + 1'b1;
                    if (phase_timer >= wake_ticks_cfg)
                    begin
                        rd_phase = RD_RELEASE;
                        phase_timer = '0;
                    end
                end
                RD_RELEASE:
                begin
                    phase_timer = phase_timer + 1'b1;
                    if (phase_timer >= RELEASE_TICKS)
                    begin
                        phase_timer = '0;
                        rd_phase = RD_SAMPLE;
                        if (edge_index >= max_edges_cfg)
                            done = 1'b1;
                    end
                end
                RD_SAMPLE:
                begin
                    if (pin == last_level)
                    begin
                        level_count = level_count + 1'b1;
                        if (level_count >= TIMEOUT_TICKS)
                        begin
                            done = 1'b1;
                            tmo = 1'b1;
                        end
                    end
                    else
                    begin
                        last_level = pin;
                        // bits are timed on the high level closed by the even edges from four, up to forty bits
                        if (edge_index >= FIRST_DATA_EDGE && !edge_index[0]
                            && bit_count < MAX_BITS)
                        begin
                            byte_pos = BYTE_W * (NUM_BYTES - 1 - (bit_count >> 3));
                            cur = rx_bits[byte_pos +: BYTE_W];
                            rx_bits[byte_pos +: BYTE_W] =
                                {cur[BYTE_W-2:0], level_count > ONE_THRESHOLD};
                            bit_count = bit_count + 1'b1;
                        end
                        edge_index = edge_index + 1'b1;
                        level_count = '0;
                        if (edge_index >= max_edges_cfg)
                            done = 1'b1;
                    end
                end
                default:
                    ;
            endcase
        end
        if (done)
        begin
            rd_phase = RD_IDLE;
            reads_finished++;
        end
        r = '0;
        r.drive_low = (rd_phase == RD_WAKE);
        r.busy = (rd_phase != RD_IDLE);
        if (done)
        begin
            r.done = 1'b1;
            r.timed_out = tmo;
            r.hum_whole = rx_bits[39:32];
            r.hum_tenths = rx_bits[31:24];
            r.temp_whole = rx_bits[23:16];
            r.temp_tenths = rx_bits[15:8];
            r.check = rx_bits[7:0];
            sum = SUM_W'(r.hum_whole) + SUM_W'(r.hum_tenths) + SUM_W'(r.temp_whole)
                + SUM_W'(r.temp_tenths);
            r.checksum_ok = (sum == SUM_W'(r.check)) && (sum != 0);
        end
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic send_item(input op_t op, input logic pin);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 20);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= op;
        item_ch.pin_level <= pin;
        burst_left--;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pending_readings.push_back(predict_reading(op, pin));
        items_sent++;
    endtask

    // stops sending, then waits for every reading to come back
    task automatic settle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WAKE_TICKS)
            wake_ticks_cfg = data[WAKE_W-1:0];
        else
            max_edges_cfg = data[EDGE_W-1:0];
    endtask

    // only sent while sampling, the rest of a level is dropped once the read ends
    task automatic send_level(input logic pin, input int unsigned ticks);
        repeat (ticks)
            if (rd_phase == RD_SAMPLE)
                send_item(OP_TICK, pin);
    endtask

    task automatic start_read();
        send_item(OP_START, 1'($urandom_range(0, 1)));
        while (rd_phase == RD_WAKE || rd_phase == RD_RELEASE)
            send_item(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_response();
        send_level(1'b1, $urandom_range(0, 2));
        send_level(1'b0, $urandom_range(2, 6));
        send_level(1'b1, $urandom_range(2, 6));
    endtask

    function automatic int unsigned high_ticks(input logic one);
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (one)
            return (pick == 0) ? 18 : $urandom_range(18, 22);
        return (pick == 0) ? 17 : $urandom_range(1, 3);
    endfunction

    function automatic logic [DATA_BITS-1:0] random_frame();
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic [BYTE_W-1:0] b4;
        logic [SUM_W-1:0]  sum;
        int unsigned       style;
        style = $urandom_range(0, 3);
        if (style >= 2)
        begin
            b0 = 8'($urandom_range(0, 99));
            b1 = 8'($urandom_range(0, 9));
            b2 = 8'($urandom_range(0, 60));
            b3 = 8'($urandom_range(0, 9));
        end
        else
        begin
            b0 = 8'($urandom_range(0, 255));
            b1 = 8'($urandom_range(0, 255));
            b2 = 8'($urandom_range(0, 255));
            b3 = 8'($urandom_range(0, 255));
        end
        sum = SUM_W'(b0) + SUM_W'(b1) + SUM_W'(b2) + SUM_W'(b3);
        b4 = sum[BYTE_W-1:0];
        if (style == 0)
            b4 = 8'($urandom_range(0, 255));
        else if (style == 3)
            b4 = b4 ^ (8'd1 << $urandom_range(0, 7));
        return {b0, b1, b2, b3, b4};
    endfunction

    // response and data bits of a read that is already sampling
    task automatic send_frame(input logic [DATA_BITS-1:0] frame, input read_fault_t fault);
        int unsigned fault_bit;
        int unsigned n;
        logic        one;
        fault_bit = $urandom_range(0, 4);
        send_response();
        n = 0;
        while (rd_phase == RD_SAMPLE && n < 300)
        begin
            if (n == fault_bit)
            begin
                case (fault)
                    FAULT_STALL:
                        send_level(last_level, 260);
                    FAULT_RESTART:
                    begin
                        start_read();
                        send_response();
                        n = 0;
                    end
                    FAULT_NOISE:
                        repeat ($urandom_range(1, 10))
                            send_level(1'($urandom_range(0, 1)), 1);
                    default:
                        ;
                endcase
                fault_bit = 1000;
            end
            one = (n < DATA_BITS) ? frame[DATA_BITS-1-n] : 1'($urandom_range(0, 1));
            send_level(1'b0, $urandom_range(1, 2));
            send_level(1'b1, high_ticks(one));
            n++;
        end
    endtask

    task automatic send_reading(input logic [DATA_BITS-1:0] frame, input read_fault_t fault);
        start_read();
        send_frame(frame, fault);
    endtask

    task automatic test_idle_ticks();
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
    endtask

    // first read starts on the reset register values, the wake is then cut short
    task automatic test_reset_config_read();
        send_item(OP_START, 1'b0);
        repeat (20)
            send_item(OP_TICK, 1'($urandom_range(0, 1)));
        write_reg(CFG_WAKE_TICKS, 16'd23);
        while (rd_phase == RD_WAKE || rd_phase == RD_RELEASE)
            send_item(OP_TICK, 1'($urandom_range(0, 1)));
        send_frame(40'h01_00_00_00_01, FAULT_NONE);
        send_item(OP_TICK, 1'b1);
    endtask

    // sum over a byte must not wrap onto the check byte, extra bits past forty are dropped
    task automatic test_checksum_cases();
        write_reg(CFG_WAKE_TICKS, 16'd1);
        write_reg(CFG_MAX_EDGES, 16'd90);
        send_reading(40'h80_80_00_00_00, FAULT_NONE);
    endtask

    // zero edges ends each read as soon as the release is over
    task automatic test_wake_extremes();
        write_reg(CFG_MAX_EDGES, {8'hA5, 8'd0});
        write_reg(CFG_WAKE_TICKS, 16'd0);
        start_read();
        write_reg(CFG_WAKE_TICKS, 16'd1);
        start_read();
        // longest wake, shortened part way through
        write_reg(CFG_WAKE_TICKS, 16'hFFFF);
        send_item(OP_START, 1'b1);
        repeat (3)
            send_item(OP_TICK, 1'b0);
        write_reg(CFG_WAKE_TICKS, 16'd2);
        while (rd_phase == RD_WAKE || rd_phase == RD_RELEASE)
            send_item(OP_TICK, 1'($urandom_range(0, 1)));
        send_item(OP_TICK, 1'b0);
    endtask

    task automatic test_edge_limits();
        int unsigned limits[2] = '{1, 5};
        write_reg(CFG_WAKE_TICKS, 16'd1);
        foreach (limits[i])
        begin
            write_reg(CFG_MAX_EDGES, {8'($urandom_range(0, 255)), 8'(limits[i])});
            send_reading(random_frame(), FAULT_NONE);
        end
    endtask

    task automatic test_timeouts();
        write_reg(CFG_MAX_EDGES, 16'd85);
        write_reg(CFG_WAKE_TICKS, 16'd1);
        start_read();
        send_level(1'b1, 260);
    endtask

    task automatic test_restarts();
        write_reg(CFG_MAX_EDGES, 16'd12);
        write_reg(CFG_WAKE_TICKS, 16'd8);
        send_item(OP_START, 1'b0);
        repeat (3) send_item(OP_TICK, 1'b1);
        send_item(OP_START, 1'b1);
        while (rd_phase == RD_WAKE)
            send_item(OP_TICK, 1'b0);
        repeat (5) send_item(OP_TICK, 1'b1);
        write_reg(CFG_WAKE_TICKS, 16'd1);
        // restart in the release, then again while sampling
        start_read();
        send_response();
        send_level(1'b0, 2);
        send_level(1'b1, 20);
        start_read();
        send_response();
    endtask

    task automatic test_random_reads();
        int unsigned           first_done;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] wake;
        logic [EDGE_W-1:0]     edges;
        read_fault_t           fault;
        first_done = reads_finished;
        while (items_sent < ITEM_TARGET || reads_finished - first_done < RANDOM_READS)
        begin
            pick = $urandom_range(0, 9);
            wake = (pick < 8) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(41, 120));
            pick = $urandom_range(0, 9);
            edges = (pick < 2) ? 8'd85 : (pick < 8) ? 8'($urandom_range(4, 30))
                                       : 8'($urandom_range(0, 3));
            write_reg(CFG_WAKE_TICKS, wake);
            write_reg(CFG_MAX_EDGES, {8'($urandom_range(0, 255)), edges});
            pick = $urandom_range(0, 9);
            fault = (pick < 6) ? FAULT_NONE : (pick < 7) ? FAULT_STALL
                                            : (pick < 8) ? FAULT_RESTART : FAULT_NOISE;
            send_reading(random_frame(), fault);
            repeat ($urandom_range(0, 4))
                send_item(OP_TICK, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : result_checker
        reading_t    want;
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        logic        hold_val;
        int unsigned tick;
        result_ch.ready <= 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_val = 1'b0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_readings.size() == 0)
                    report("reading with no request waiting");
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("drive_low", result_ch.drive_low, want.drive_low);
                    check_field("busy_res", result_ch.busy_res, want.busy);
                    check_field("done_res", result_ch.done_res, want.done);
                    check_field("timed_out", result_ch.timed_out, want.timed_out);
                    check_field("checksum_ok", result_ch.checksum_ok, want.checksum_ok);
                    check_field("humidity_whole", result_ch.humidity_whole, want.hum_whole);
                    check_field("humidity_tenths", result_ch.humidity_tenths, want.hum_tenths);
                    check_field("temperature_whole", result_ch.temperature_whole,
                                want.temp_whole);
                    check_field("temperature_tenths", result_ch.temperature_tenths,
                                want.temp_tenths);
                    check_field("check_byte", result_ch.check_byte, want.check);
                end
            end
            // stall pattern: free running, random, periodic, long on and off runs
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            case (mode)
                0:
                    result_ch.ready <= 1'b1;
                1:
                    result_ch.ready <= ($urandom_range(0, 9) < 7);
                2:
                    result_ch.ready <= (tick % 3 == 0);
                default:
                begin
                    if (hold_left == 0)
                    begin
                        hold_val = !hold_val;
                        hold_left = $urandom_range(1, 12);
                    end
                    hold_left--;
                    result_ch.ready <= hold_val;
                end
            endcase
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.command <= OP_TICK;
        item_ch.pin_level <= 1'b0;
        wake_ticks_cfg = WAKE_TICKS_RESET;
        max_edges_cfg = MAX_EDGES_RESET;
        rd_phase = RD_IDLE;
        phase_timer = '0;
        level_count = '0;
        edge_index = '0;
        last_level = 1'b1;
        bit_count = '0;
        rx_bits = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_reset_config_read();
        test_checksum_cases();
        test_wake_extremes();
        test_edge_limits();
        test_timeouts();
        test_restarts();
        test_random_reads();
        settle();

        if (mismatches == 0 && pending_readings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
